/* design/tpaq_pkg.sv */
// Package for the two-priority action queue.
// Holds the operation codes and the fixed field widths; no dependencies.
`default_nettype none

package tpaq_pkg;

    // Operation carried in the low bits of the input tuser
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_PEEK   = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    localparam int CODE_W = 8;   // action code width
    localparam int PROG_W = 8;   // progress word width
    localparam int POS_W  = 8;   // peek / delete position width

endpackage

`default_nettype wire

/* design/two_priority_action_queue.sv */
// Two-priority action queue: urgent and normal circular queues of action entries.
// Depends on tpaq_pkg for the operation codes and field widths.
//
// Each transaction on the input stream carries one operation (push, pop, peek
// or delete) and produces exactly one result transaction in the cycle after it is
// accepted. One operation is accepted every cycle while the result side takes
// results; s_tready follows m_tready combinationally when a result is held.
// Pointer compare and update, the store write and the registered store read
// all happen in the accepting cycle. Each queue holds one entry fewer than its
// depth. Peek and delete count positions over the urgent entries first, then
// the normal ones; pop takes the oldest urgent entry, else the oldest normal.
// A delete replaces the entry's action code with the cancelled code written
// through cfg_we / cfg_wdata. Both depths must be powers of two.
`default_nettype none

module two_priority_action_queue
    import tpaq_pkg::*;
#(
    parameter int URGENT_DEPTH = 8,
    parameter int NORMAL_DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [POS_W+PROG_W+CODE_W-1:0] s_tdata,  // entry_action, entry_progress, position
    input  wire logic [2:0]                 s_tuser,  // action[1:0], urgent[2]

    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [PROG_W+CODE_W-1:0]        m_tdata,  // out_action, out_progress
    output logic [0:0]                      m_tuser,  // ok

    input  wire logic                       cfg_we,
    input  wire logic [CODE_W-1:0]          cfg_wdata
);

    localparam int UW = $clog2(URGENT_DEPTH);
    localparam int NW = $clog2(NORMAL_DEPTH);

    // Stores, split into action and progress halves so delete touches one half
    logic [CODE_W-1:0] u_act_mem  [URGENT_DEPTH];
    logic [PROG_W-1:0] u_prog_mem [URGENT_DEPTH];
    logic [CODE_W-1:0] n_act_mem  [NORMAL_DEPTH];
    logic [PROG_W-1:0] n_prog_mem [NORMAL_DEPTH];

    logic [UW-1:0]     u_head_reg, u_head_next, u_tail_reg, u_tail_next;
    logic [NW-1:0]     n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [CODE_W-1:0] cancelled_code_reg;

    logic              m_valid_reg;
    logic              ok_reg, ok_next;
    logic              show_reg, show_next;
    logic              sel_u_reg, sel_u_next;
    logic [CODE_W-1:0] u_act_rd_reg, n_act_rd_reg;
    logic [PROG_W-1:0] u_prog_rd_reg, n_prog_rd_reg;

    logic              accept;
    op_t               op;
    logic              in_urgent;
    logic [CODE_W-1:0] in_code;
    logic [PROG_W-1:0] in_prog;
    logic [POS_W-1:0]  in_pos, eff_pos, n_pos;
    logic [UW-1:0]     u_cnt, u_slot;
    logic [NW-1:0]     n_cnt, n_slot;
    logic              u_hit, n_hit, u_full, n_full;

    logic              u_act_we, u_prog_we, n_act_we, n_prog_we;
    logic [UW-1:0]     u_waddr;
    logic [NW-1:0]     n_waddr;
    logic [CODE_W-1:0] act_wdata;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign op        = op_t'(s_tuser[1:0]);
    assign in_urgent = s_tuser[2];
    assign in_code   = s_tdata[CODE_W-1:0];
    assign in_prog   = s_tdata[CODE_W+PROG_W-1:CODE_W];
    assign in_pos    = s_tdata[CODE_W+PROG_W+POS_W-1:CODE_W+PROG_W];

    always_comb
    begin
        // A pop is a lookup of position zero that also advances a head
        eff_pos = (op == OP_POP) ? '0 : in_pos;
        u_cnt   = u_tail_reg - u_head_reg;
        n_cnt   = n_tail_reg - n_head_reg;
        u_hit   = eff_pos < POS_W'(u_cnt);
        n_pos   = eff_pos - POS_W'(u_cnt);
        n_hit   = !u_hit && (n_pos < POS_W'(n_cnt));
        u_slot  = u_head_reg + eff_pos[UW-1:0];
        n_slot  = n_head_reg + n_pos[NW-1:0];
        u_full  = (u_tail_reg + UW'(1)) == u_head_reg;
        n_full  = (n_tail_reg + NW'(1)) == n_head_reg;

        u_head_next = u_head_reg;
        u_tail_next = u_tail_reg;
        n_head_next = n_head_reg;
        n_tail_next = n_tail_reg;
        ok_next     = 1'b0;
        show_next   = 1'b0;
        sel_u_next  = u_hit;
        u_act_we    = 1'b0;
        u_prog_we   = 1'b0;
        n_act_we    = 1'b0;
        n_prog_we   = 1'b0;
        u_waddr     = u_slot;
        n_waddr     = n_slot;
        act_wdata   = cancelled_code_reg;

        case (op)
            OP_PUSH:
            begin
                act_wdata = in_code;
                u_waddr   = u_tail_reg;
                n_waddr   = n_tail_reg;
                if (in_urgent)
                begin
                    ok_next   = !u_full;
                    u_act_we  = !u_full;
                    u_prog_we = !u_full;
                    if (!u_full)
                        u_tail_next = u_tail_reg + UW'(1);
                end
                else
                begin
                    ok_next   = !n_full;
                    n_act_we  = !n_full;
                    n_prog_we = !n_full;
                    if (!n_full)
                        n_tail_next = n_tail_reg + NW'(1);
                end
            end
            OP_POP:
            begin
                ok_next   = u_hit || n_hit;
                show_next = u_hit || n_hit;
                if (u_hit)
                    u_head_next = u_head_reg + UW'(1);
                else if (n_hit)
                    n_head_next = n_head_reg + NW'(1);
            end
            OP_PEEK:
            begin
                ok_next   = u_hit || n_hit;
                show_next = u_hit || n_hit;
            end
            OP_DELETE:
            begin
                ok_next  = u_hit || n_hit;
                u_act_we = u_hit;
                n_act_we = n_hit;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_head_reg         <= '0;
            u_tail_reg         <= '0;
            n_head_reg         <= '0;
            n_tail_reg         <= '0;
            cancelled_code_reg <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cancelled_code_reg <= cfg_wdata;
            if (accept)
            begin
                u_head_reg <= u_head_next;
                u_tail_reg <= u_tail_next;
                n_head_reg <= n_head_next;
                n_tail_reg <= n_tail_next;
            end
            if (accept)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Result flags and store reads; hold while the result is stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= ok_next;
            show_reg      <= show_next;
            sel_u_reg     <= sel_u_next;
            u_act_rd_reg  <= u_act_mem[u_slot];
            u_prog_rd_reg <= u_prog_mem[u_slot];
            n_act_rd_reg  <= n_act_mem[n_slot];
            n_prog_rd_reg <= n_prog_mem[n_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && u_act_we)
            u_act_mem[u_waddr] <= act_wdata;
        if (accept && u_prog_we)
            u_prog_mem[u_waddr] <= in_prog;
        if (accept && n_act_we)
            n_act_mem[n_waddr] <= act_wdata;
        if (accept && n_prog_we)
            n_prog_mem[n_waddr] <= in_prog;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = ok_reg;

    always_comb
    begin
        if (!show_reg)
            m_tdata = '0;
        else if (sel_u_reg)
            m_tdata = {u_prog_rd_reg, u_act_rd_reg};
        else
            m_tdata = {n_prog_rd_reg, n_act_rd_reg};
    end

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the two-priority action queue.
// Depends on tpaq_pkg and two_priority_action_queue; drives both streams and
// predicts each result with its own copy of the two queues.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tpaq_pkg::*;

    localparam int U_DEPTH     = 8;
    localparam int N_DEPTH     = 16;
    localparam int U_W         = $clog2(U_DEPTH);
    localparam int N_W         = $clog2(N_DEPTH);
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 290;
    localparam int LIMIT       = 250000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic        ok;
        logic [7:0]  prog;
        logic [7:0]  act;
    } result_t;

    typedef struct {
        op_t         op;
        logic        urg;
        logic [7:0]  code;
        logic [7:0]  prog;
        logic [7:0]  pos;
        bit          typed;
        result_t     want;
    } row_t;

    logic                               clk;
    logic                               rst_n;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [POS_W+PROG_W+CODE_W-1:0]     s_tdata;   // entry_action, entry_progress, position
    logic [2:0]                         s_tuser;   // action[1:0], urgent[2]
    logic                               m_tvalid;
    logic                               m_tready;
    logic [PROG_W+CODE_W-1:0]           m_tdata;   // out_action, out_progress
    logic [0:0]                         m_tuser;   // ok
    logic                               cfg_we;
    logic [CODE_W-1:0]                  cfg_wdata;

    two_priority_action_queue #(
        .URGENT_DEPTH (U_DEPTH),
        .NORMAL_DEPTH (N_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted queue contents and pointers
    logic [15:0]    urgent_slots [U_DEPTH];
    logic [15:0]    normal_slots [N_DEPTH];
    logic [U_W-1:0] u_head = '0;
    logic [U_W-1:0] u_tail = '0;
    logic [N_W-1:0] n_head = '0;
    logic [N_W-1:0] n_tail = '0;
    logic [7:0]     cancel_code = '0;

    result_t        awaited_results [$];
    row_t           plan [$];
    bit             cur_typed;
    result_t        cur_want;
    bit             calm = 0;
    int             idle_pct = 0;
    int             stall_pct = 0;

    int             mismatches = 0;
    int             items_sent = 0;
    int             results_seen = 0;
    int             urgent_full_hits = 0;
    int             normal_full_hits = 0;
    int             empty_pops = 0;
    int             out_of_range = 0;
    int             deletes_done = 0;

    // Apply one operation to the predicted queues and return its result
    function automatic result_t queue_op_result(op_t op, logic urg, logic [7:0] code,
                                                logic [7:0] prog, logic [7:0] pos);
        result_t        r;
        logic [U_W-1:0] ucount;
        logic [N_W-1:0] ncount;
        logic [U_W-1:0] u_next;
        logic [N_W-1:0] n_next;
        logic [U_W-1:0] us;
        logic [N_W-1:0] ns;
        logic [7:0]     rel;
        r      = '0;
        ucount = u_tail - u_head;
        ncount = n_tail - n_head;
        u_next = u_tail + 1'b1;
        n_next = n_tail + 1'b1;
        rel    = pos - ucount;
        us     = u_head + pos[U_W-1:0];
        ns     = n_head + rel[N_W-1:0];
        case (op)
            OP_PUSH:
                if (urg)
                begin
                    if (u_next == u_head)
                        urgent_full_hits++;
                    else
                    begin
                        urgent_slots[u_tail] = {prog, code};
                        u_tail = u_next;
                        r.ok = 1'b1;
                    end
                end
                else
                begin
                    if (n_next == n_head)
                        normal_full_hits++;
                    else
                    begin
                        normal_slots[n_tail] = {prog, code};
                        n_tail = n_next;
                        r.ok = 1'b1;
                    end
                end
            OP_POP:
                if (ucount != 0)
                begin
                    r = {1'b1, urgent_slots[u_head]};
                    u_head++;
                end
                else if (ncount != 0)
                begin
                    r = {1'b1, normal_slots[n_head]};
                    n_head++;
                end
                else
                    empty_pops++;
            default:
                // peek and delete: urgent entries first, then normal ones
                if (pos < ucount)
                begin
                    if (op == OP_PEEK)
                        r = {1'b1, urgent_slots[us]};
                    else
                    begin
                        urgent_slots[us][7:0] = cancel_code;
                        r.ok = 1'b1;
                        deletes_done++;
                    end
                end
                else if (rel < ncount)
                begin
                    if (op == OP_PEEK)
                        r = {1'b1, normal_slots[ns]};
                    else
                    begin
                        normal_slots[ns][7:0] = cancel_code;
                        r.ok = 1'b1;
                        deletes_done++;
                    end
                end
                else
                    out_of_range++;
        endcase
        return r;
    endfunction

    function automatic result_t res(logic ok, logic [7:0] act, logic [7:0] prog);
        result_t r;
        r.ok   = ok;
        r.act  = act;
        r.prog = prog;
        return r;
    endfunction

    task automatic add_row(op_t op, logic urg, logic [7:0] code, logic [7:0] prog,
                           logic [7:0] pos, bit typed, result_t want);
        row_t r;
        r.op    = op;
        r.urg   = urg;
        r.code  = code;
        r.prog  = prog;
        r.pos   = pos;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endtask

    // Random operation; mode 0 balanced, 1 push heavy, 2 pop heavy
    function automatic row_t random_row(int mode);
        row_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        case (mode)
            1:       r.op = pick < 60 ? OP_PUSH : pick < 75 ? OP_POP :
                            pick < 88 ? OP_PEEK : OP_DELETE;
            2:       r.op = pick < 20 ? OP_PUSH : pick < 70 ? OP_POP :
                            pick < 85 ? OP_PEEK : OP_DELETE;
            default: r.op = pick < 35 ? OP_PUSH : pick < 60 ? OP_POP :
                            pick < 80 ? OP_PEEK : OP_DELETE;
        endcase
        r.urg   = 1'($urandom_range(0, 1));
        r.code  = 8'($urandom_range(0, 255));
        r.prog  = 8'($urandom_range(0, 255));
        // mostly positions near the occupied range, sometimes anywhere
        r.pos   = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 24))
                                                 : 8'($urandom_range(0, 255));
        r.typed = 0;
        r.want  = '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s: expected ok=%0d act=%02h prog=%02h, got ok=%0d act=%02h prog=%02h",
                     $realtime, what, want.ok, want.act, want.prog, got.ok, got.act, got.prog);
    endtask

    task automatic send(row_t r);
        int gap;
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 9);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid = 1'b0;
            end
        end
        @(negedge clk);
        s_tvalid  = 1'b1;
        s_tdata   = {r.pos, r.prog, r.code};
        s_tuser   = {r.urg, r.op};
        cur_typed = r.typed;
        cur_want  = r.want;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Drop valid, let every awaited result drain, then allow the pipe to settle
    task automatic drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_cancel_code(logic [7:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Predict on input transactions, check on output transactions
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (cfg_we)
                cancel_code = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                pred = queue_op_result(op_t'(s_tuser[1:0]), s_tuser[2], s_tdata[7:0],
                                       s_tdata[15:8], s_tdata[23:16]);
                awaited_results.push_back(cur_typed ? cur_want : pred);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = res(m_tuser[0], m_tdata[7:0], m_tdata[15:8]);
                if (awaited_results.size() == 0)
                    report_mismatch("unexpected result", '0, got);
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.ok !== want.ok || got.act !== want.act || got.prog !== want.prog)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Result side back-pressure in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
                m_tready = 1'b1;
        end
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results still awaited",
                 LIMIT, awaited_results.size());
        $display("two_priority_action_queue test failed");
        $finish;
    end

    initial
    begin
        int idle_by_phase [PHASES];
        int stall_by_phase [PHASES];
        logic [7:0] cfg_by_phase [PHASES];
        row_t r;

        idle_by_phase  = '{25, 0, 40, 10, 60, 0};
        stall_by_phase = '{20, 40, 0, 10, 50, 0};
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        cur_typed = 0;
        cur_want  = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part runs with the cancelled code at its reset value
        add_row(OP_POP,    1'b0, 8'h00, 8'h00, 8'h00, 1, res(0, 8'h00, 8'h00));
        add_row(OP_PEEK,   1'b1, 8'hFF, 8'hFF, 8'h00, 1, res(0, 8'h00, 8'h00));
        add_row(OP_DELETE, 1'b0, 8'h00, 8'h00, 8'hFF, 1, res(0, 8'h00, 8'h00));
        add_row(OP_PUSH,   1'b1, 8'hFF, 8'hFF, 8'h00, 1, res(1, 8'h00, 8'h00));
        add_row(OP_PUSH,   1'b0, 8'h00, 8'h00, 8'h00, 1, res(1, 8'h00, 8'h00));
        add_row(OP_PUSH,   1'b0, 8'hA5, 8'h5A, 8'hFF, 1, res(1, 8'h00, 8'h00));
        add_row(OP_PEEK,   1'b0, 8'h00, 8'h00, 8'h00, 1, res(1, 8'hFF, 8'hFF));
        add_row(OP_PEEK,   1'b1, 8'hFF, 8'hFF, 8'h01, 1, res(1, 8'h00, 8'h00));
        add_row(OP_PEEK,   1'b0, 8'h00, 8'h00, 8'h02, 1, res(1, 8'hA5, 8'h5A));
        add_row(OP_PEEK,   1'b0, 8'h00, 8'h00, 8'h03, 1, res(0, 8'h00, 8'h00));
        add_row(OP_DELETE, 1'b1, 8'h77, 8'h77, 8'h00, 1, res(1, 8'h00, 8'h00));
        // deleting the same entry twice still succeeds
        add_row(OP_DELETE, 1'b0, 8'h00, 8'h00, 8'h00, 1, res(1, 8'h00, 8'h00));
        add_row(OP_PEEK,   1'b0, 8'h00, 8'h00, 8'h00, 1, res(1, 8'h00, 8'hFF));
        add_row(OP_POP,    1'b1, 8'hFF, 8'hFF, 8'hFF, 1, res(1, 8'h00, 8'hFF));
        add_row(OP_POP,    1'b0, 8'h00, 8'h00, 8'h00, 1, res(1, 8'h00, 8'h00));
        add_row(OP_POP,    1'b0, 8'h00, 8'h00, 8'h00, 1, res(1, 8'hA5, 8'h5A));
        add_row(OP_POP,    1'b0, 8'h00, 8'h00, 8'h00, 1, res(0, 8'h00, 8'h00));
        // fill the urgent queue; the last push finds it full
        for (int i = 0; i < U_DEPTH - 1; i++)
            add_row(OP_PUSH, 1'b1, 8'(8'h11 * i), 8'(8'hF0 - i), 8'(i), 0, '0);
        add_row(OP_PUSH,   1'b1, 8'h12, 8'h34, 8'h00, 1, res(0, 8'h00, 8'h00));

        idle_pct  = 20;
        stall_pct = 20;
        foreach (plan[i])
            send(plan[i]);
        drain();

        cfg_by_phase = '{8'hFF, 8'h00, 8'($urandom_range(0, 255)), 8'h80,
                         8'($urandom_range(0, 255)), 8'h01};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_cancel_code(cfg_by_phase[ph]);
            idle_pct  = idle_by_phase[ph];
            stall_pct = stall_by_phase[ph];
            calm      = (ph == PHASES - 1);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                r = random_row(ph % 3);
                send(r);
            end
            drain();
        end

        repeat (4) @(posedge clk);
        if (awaited_results.size() != 0)
        begin
            $display("%0d results never arrived", awaited_results.size());
            mismatches += awaited_results.size();
        end

        $display("%0d operations over %0d cancelled-code settings, %0d results checked",
                 items_sent, PHASES + 1, results_seen);
        $display("refusals: urgent full %0d, normal full %0d, empty pop %0d, bad position %0d;"
                 , urgent_full_hits, normal_full_hits, empty_pops, out_of_range);
        $display("deletes %0d, mismatches %0d", deletes_done, mismatches);
        if (mismatches == 0)
            $display("two_priority_action_queue test passed");
        else
            $display("two_priority_action_queue test failed");
        $finish;
    end

endmodule

`default_nettype wire

/* two_priority_action_queue.f */
design/tpaq_pkg.sv
design/two_priority_action_queue.sv
sim/tb.sv
